### hw/rtl/assert_macros.svh
// Assertion macros used by the sampler core; clocked on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ESMP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ESMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/esmp_pkg.sv
// Shared constants, types and helpers of the environment map sampler.
package esmp_pkg;

    localparam int DIR_W        = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int DROP         = 32 - ANGLE_BITS;
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 128;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT);
    localparam int WCFG_W       = 9;
    localparam int HCFG_W       = 8;
    localparam int CFG_W        = 9;
    localparam int COLOR_W      = 32;
    localparam int CORDIC_STEPS = 24;
    localparam int OP_SH        = 14;
    localparam int OPW          = 36;
    localparam int ACC_W        = 34;
    localparam int SQ_ROOT_W    = 30;
    localparam int SQ_SH        = 28;
    localparam int SQ_IN_W      = 2 * DIR_W + SQ_SH;
    localparam int SQ_REM_W     = SQ_IN_W + 1;

    localparam logic [COLOR_W-1:0] MAGENTA = 32'hFFFF_00FF;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] TURN_TABLE [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [1:0] {
        REG_MAP_WIDTH   = 2'd0,
        REG_MAP_HEIGHT  = 2'd1,
        REG_MAP_PRESENT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic               cmd;
        logic               xz_zero;
        logic               y_zero;
        logic               y_neg;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] value;
    } item_t;

    function automatic logic signed [OPW-1:0] scale_dir(input logic signed [DIR_W-1:0] d);
        return OPW'(d) <<< OP_SH;
    endfunction

endpackage

### hw/rtl/esmp_cordic.sv
// Pipelined vectoring CORDIC, one iteration per stage, angle in 2^-32 turn.
module esmp_cordic import esmp_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [OPW-1:0]   px,
    input  logic signed [OPW-1:0]   py,
    output logic signed [ACC_W-1:0] angle
);

    localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(64'd1073741824);

    logic signed [OPW-1:0]   x0;
    logic signed [OPW-1:0]   y0;
    logic signed [ACC_W-1:0] a0;
    logic signed [OPW-1:0]   x_reg [CORDIC_STEPS];
    logic signed [OPW-1:0]   y_reg [CORDIC_STEPS];
    logic signed [ACC_W-1:0] acc_reg [CORDIC_STEPS];

    // fold the left half plane onto the right one
    always_comb
    begin
        x0 = px;
        y0 = py;
        a0 = '0;
        if (px < 0)
        begin
            if (py >= 0)
            begin
                x0 = py;
                y0 = -px;
                a0 = QUARTER_TURN;
            end
            else
            begin
                x0 = -py;
                y0 = px;
                a0 = -QUARTER_TURN;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [OPW-1:0]   xi;
        logic signed [OPW-1:0]   yi;
        logic signed [ACC_W-1:0] ai;
        logic signed [OPW-1:0]   xs;
        logic signed [OPW-1:0]   ys;
        logic signed [ACC_W-1:0] ti;

        if (i == 0)
        begin : g_first
            assign xi = x0;
            assign yi = y0;
            assign ai = a0;
        end
        else
        begin : g_rest
            assign xi = x_reg[i-1];
            assign yi = y_reg[i-1];
            assign ai = acc_reg[i-1];
        end

        assign xs = xi >>> i;
        assign ys = yi >>> i;
        assign ti = $signed({{(ACC_W-32){1'b0}}, TURN_TABLE[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (yi > 0)
                begin
                    x_reg[i]   <= xi + ys;
                    y_reg[i]   <= yi - xs;
                    acc_reg[i] <= ai + ti;
                end
                else
                begin
                    x_reg[i]   <= xi - ys;
                    y_reg[i]   <= yi + xs;
                    acc_reg[i] <= ai - ti;
                end
            end
        end
    end

    assign angle = acc_reg[CORDIC_STEPS-1];

endmodule

### hw/rtl/esmp_isqrt.sv
// Pipelined floor square root, one root bit per stage.
module esmp_isqrt import esmp_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [SQ_IN_W-1:0]   n,
    output logic [SQ_ROOT_W-1:0] root
);

    logic [SQ_REM_W-1:0]  rem_reg  [SQ_ROOT_W-1];
    logic [SQ_ROOT_W-1:0] root_reg [SQ_ROOT_W];

    for (genvar s = 0; s < SQ_ROOT_W; s++)
    begin : g_stage
        localparam int K = SQ_ROOT_W - 1 - s;
        logic [SQ_REM_W-1:0]  rem_i;
        logic [SQ_ROOT_W-1:0] root_i;
        logic [SQ_REM_W-1:0]  trial;
        logic                 take;

        if (s == 0)
        begin : g_first
            assign rem_i  = SQ_REM_W'(n);
            assign root_i = '0;
        end
        else
        begin : g_rest
            assign rem_i  = rem_reg[s-1];
            assign root_i = root_reg[s-1];
        end

        assign trial = (SQ_REM_W'(root_i) << (K + 1)) + (SQ_REM_W'(1) << (2 * K));
        assign take  = (rem_i >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= take ? (root_i | (SQ_ROOT_W'(1) << K)) : root_i;
            end
        end

        if (s < SQ_ROOT_W - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s] <= take ? (rem_i - trial) : rem_i;
                end
            end
        end
    end

    assign root = root_reg[SQ_ROOT_W-1];

endmodule

### hw/rtl/esmp_texel_store.sv
// Texel memory: one address port for both write and read, registered read data.
module esmp_texel_store import esmp_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic               re,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [COLOR_W-1:0] wdata,
    output logic [COLOR_W-1:0] rdata
);

    logic [COLOR_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

### hw/rtl/equirect_env_map_sampler_core.sv
// Equirectangular environment map sampler, top level.
// Path: an accepted beat passes the square, sum, 30-stage square root, 24-stage CORDIC
// pair, three mapping stages and one memory read stage before its result beat.
// Throughput: one beat per clock; the whole pipeline holds only while m_tready is low.
// Reset: pipeline empty, map 256 x 128, no map present; texel memory contents undefined.
`include "assert_macros.svh"

module equirect_env_map_sampler_core import esmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [95:0]      s_tdata,   // dir_x, dir_y, dir_z, texel_address, texel_value, pad
    input  logic [0:0]       s_tuser,   // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata    // color, column, row, pad
);

    localparam int XYZ_LEN  = 2 + SQ_ROOT_W;
    localparam int PIPE_LEN = XYZ_LEN + CORDIC_STEPS;
    localparam logic signed [ACC_W+1:0] HALF_TURN_V = (ACC_W+2)'(64'd2147483648);
    localparam logic signed [ACC_W-1:0] HALF_TURN_U = ACC_W'(64'd2147483648);
    localparam logic [32:0] FULL_TURN  = 33'h1_0000_0000;
    localparam logic [33:0] ROUND_HALF = 34'(64'd1 << (DROP - 1));

    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    logic              present_reg;
    logic [WCFG_W-1:0] w_eff;
    logic [HCFG_W-1:0] h_eff;

    logic adv;

    logic signed [DIR_W-1:0] in_x;
    logic signed [DIR_W-1:0] in_y;
    logic signed [DIR_W-1:0] in_z;
    item_t                   in_item;
    logic signed [2*DIR_W-1:0] sqx;
    logic signed [2*DIR_W-1:0] sqz;
    logic [2*DIR_W-2:0]      sqx_reg;
    logic [2*DIR_W-2:0]      sqz_reg;
    logic [SQ_IN_W-1:0]      n_reg;
    logic [2*DIR_W-1:0]      r2;
    logic [SQ_ROOT_W-1:0]    root;

    logic [PIPE_LEN-1:0]     vld_reg;
    item_t                   pipe_reg [PIPE_LEN];
    logic signed [DIR_W-1:0] x_reg [XYZ_LEN];
    logic signed [DIR_W-1:0] y_reg [XYZ_LEN];
    logic signed [DIR_W-1:0] z_reg [XYZ_LEN];

    logic signed [ACC_W-1:0] au;
    logic signed [ACC_W-1:0] av;
    item_t                   last_item;

    logic [31:0]               u32;
    logic [32:0]               u_rnd;
    logic signed [ACC_W+1:0]   v_raw;
    logic [32:0]               v32;
    logic [33:0]               v_rnd;
    logic [ANGLE_BITS-1:0]     uq_next;
    logic [ANGLE_BITS:0]       vq_next;

    logic                  q1_vld_reg;
    item_t                 q1_item_reg;
    logic [ANGLE_BITS-1:0] uq_reg;
    logic [ANGLE_BITS:0]   vq_reg;

    logic [ANGLE_BITS+WCFG_W-1:0] col_prod;
    logic [ANGLE_BITS+HCFG_W:0]   row_prod;
    logic [HCFG_W-1:0]            row_raw;
    logic [HCFG_W-1:0]            row_clamp;

    logic              q2_vld_reg;
    item_t             q2_item_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    logic [ROW_W+WCFG_W:0] addr_sum;
    logic              q3_vld_reg;
    item_t             q3_item_reg;
    logic [COL_W-1:0]  q3_col_reg;
    logic [ROW_W-1:0]  q3_row_reg;
    logic [ADDR_W-1:0] q3_addr_reg;

    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [COLOR_W-1:0] mem_rdata;

    logic              out_vld_reg;
    logic              magenta_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WCFG_W'(MAX_WIDTH);
            height_reg  <= HCFG_W'(MAX_HEIGHT);
            present_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAP_WIDTH:   width_reg   <= cfg_wr_data[WCFG_W-1:0];
                REG_MAP_HEIGHT:  height_reg  <= cfg_wr_data[HCFG_W-1:0];
                REG_MAP_PRESENT: present_reg <= cfg_wr_data[0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg == '0)
            w_eff = WCFG_W'(1);
        else if (width_reg > WCFG_W'(MAX_WIDTH))
            w_eff = WCFG_W'(MAX_WIDTH);
        h_eff = height_reg;
        if (height_reg == '0)
            h_eff = HCFG_W'(1);
        else if (height_reg > HCFG_W'(MAX_HEIGHT))
            h_eff = HCFG_W'(MAX_HEIGHT);
    end

    // advance everything while the output register is free or drained
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    assign in_x = s_tdata[15:0];
    assign in_y = s_tdata[31:16];
    assign in_z = s_tdata[47:32];

    always_comb
    begin
        in_item.cmd     = s_tuser[0];
        in_item.xz_zero = (in_x == '0) && (in_z == '0);
        in_item.y_zero  = (in_y == '0);
        in_item.y_neg   = in_y[DIR_W-1];
        in_item.addr    = s_tdata[62:48];
        in_item.value   = s_tdata[94:63];
    end

    assign sqx = in_x * in_x;
    assign sqz = in_z * in_z;
    assign r2  = {1'b0, sqx_reg} + {1'b0, sqz_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg[0] <= in_item;
            x_reg[0]    <= in_x;
            y_reg[0]    <= in_y;
            z_reg[0]    <= in_z;
            sqx_reg     <= sqx[2*DIR_W-2:0];
            sqz_reg     <= sqz[2*DIR_W-2:0];
            n_reg       <= {r2, {SQ_SH{1'b0}}};
            for (int k = 1; k < PIPE_LEN; k++)
                pipe_reg[k] <= pipe_reg[k-1];
            for (int k = 1; k < XYZ_LEN; k++)
            begin
                x_reg[k] <= x_reg[k-1];
                y_reg[k] <= y_reg[k-1];
                z_reg[k] <= z_reg[k-1];
            end
        end
    end

    esmp_isqrt u_isqrt
    (
        .clk  (clk),
        .en   (adv),
        .n    (n_reg),
        .root (root)
    );

    esmp_cordic u_cordic_u
    (
        .clk   (clk),
        .en    (adv),
        .px    (scale_dir(x_reg[XYZ_LEN-1])),
        .py    (scale_dir(z_reg[XYZ_LEN-1])),
        .angle (au)
    );

    esmp_cordic u_cordic_v
    (
        .clk   (clk),
        .en    (adv),
        .px    ($signed(OPW'(root))),
        .py    (scale_dir(y_reg[XYZ_LEN-1])),
        .angle (av)
    );

    assign last_item = pipe_reg[PIPE_LEN-1];

    // angles to quantized fractions
    always_comb
    begin
        u32   = 32'(au + HALF_TURN_U);
        u_rnd = {1'b0, u32} + ROUND_HALF[32:0];
        v_raw = HALF_TURN_V - ((ACC_W+2)'(av) <<< 1);
        if (v_raw < 0)
            v32 = '0;
        else if (v_raw > $signed({{(ACC_W+2-33){1'b0}}, FULL_TURN}))
            v32 = FULL_TURN;
        else
            v32 = v_raw[32:0];
        v_rnd   = {1'b0, v32} + ROUND_HALF;
        uq_next = u_rnd[31:DROP];
        vq_next = v_rnd[32:DROP];
        if (last_item.xz_zero)
        begin
            uq_next = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
            if (last_item.y_zero)
                vq_next = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1);
            else if (last_item.y_neg)
                vq_next = (ANGLE_BITS+1)'(1) << ANGLE_BITS;
            else
                vq_next = '0;
        end
    end

    assign col_prod  = uq_reg * w_eff;
    assign row_prod  = vq_reg * h_eff;
    assign row_raw   = row_prod[ANGLE_BITS+HCFG_W-1:ANGLE_BITS];
    assign row_clamp = (row_raw >= h_eff) ? (h_eff - HCFG_W'(1)) : row_raw;
    assign addr_sum  = (ROW_W+WCFG_W+1)'(row_reg * w_eff) + (ROW_W+WCFG_W+1)'(col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_vld_reg <= 1'b0;
            q2_vld_reg <= 1'b0;
            q3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            q1_vld_reg <= vld_reg[PIPE_LEN-1];
            q2_vld_reg <= q1_vld_reg;
            q3_vld_reg <= q2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_item_reg <= last_item;
            uq_reg      <= uq_next;
            vq_reg      <= vq_next;
            q2_item_reg <= q1_item_reg;
            col_reg     <= col_prod[ANGLE_BITS+COL_W-1:ANGLE_BITS];
            row_reg     <= row_clamp[ROW_W-1:0];
            q3_item_reg <= q2_item_reg;
            q3_col_reg  <= col_reg;
            q3_row_reg  <= row_reg;
            q3_addr_reg <= addr_sum[ADDR_W-1:0];
        end
    end

    // writes and reads meet the memory in order at one stage
    assign mem_we   = adv && q3_vld_reg && !q3_item_reg.cmd;
    assign mem_re   = adv && q3_vld_reg && q3_item_reg.cmd;
    assign mem_addr = q3_item_reg.cmd ? q3_addr_reg : q3_item_reg.addr;

    esmp_texel_store u_store
    (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (q3_item_reg.value),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= q3_vld_reg && q3_item_reg.cmd;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            magenta_reg <= !present_reg;
            out_col_reg <= present_reg ? q3_col_reg : '0;
            out_row_reg <= present_reg ? q3_row_reg : '0;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_row_reg, out_col_reg, magenta_reg ? MAGENTA : mem_rdata};

    `ESMP_ASSERT_NEXT(a_pipe_hold, !adv, $stable(vld_reg) && $stable(out_vld_reg),
        "pipeline moved while stalled")
    `ESMP_ASSERT_NEXT(a_sample_out, adv && q3_vld_reg && q3_item_reg.cmd, out_vld_reg,
        "sample beat lost at memory stage")
    `ESMP_ASSERT_IMPL(a_magenta_zero, out_vld_reg && magenta_reg,
        out_col_reg == '0 && out_row_reg == '0, "no-map result with nonzero position")
    `ESMP_ASSERT_IMPL(a_no_rw, mem_we, !mem_re, "memory read and write in one cycle")

endmodule

### sim/esmp_checker.sv
// Beat monitor, environment map predictor and result comparator for the sampler.
`timescale 1ns / 1ps

module esmp_checker import esmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [95:0]      s_tdata,
    input  logic [0:0]       s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [47:0]      m_tdata,
    output int               pending,
    output int               errors
);

    typedef struct packed {
        logic [6:0]  row;
        logic [7:0]  column;
        logic [31:0] color;
    } sample_t;

    logic [COLOR_W-1:0] texels [STORE_DEPTH];
    bit                 written [STORE_DEPTH];
    logic [8:0]         width_cfg;
    logic [7:0]         height_cfg;
    logic               present_cfg;
    sample_t            expected_samples [$];
    bit                 known_q [$];
    bit                 color_known;

    assign pending = expected_samples.size();

    function automatic longint turn_angle(input longint px, input longint py);
        longint x, y, acc, t, xs, ys;
        x = px;
        y = py;
        acc = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                acc = 64'sd1073741824;
            end
            else
            begin
                x = -y;
                y = t;
                acc = -64'sd1073741824;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                acc = acc + longint'(TURN_TABLE[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                acc = acc - longint'(TURN_TABLE[i]);
            end
        end
        return acc;
    endfunction

    function automatic longint floor_root(input longint n);
        longint r, lo, hi, mid;
        lo = 0;
        hi = 64'd1 << 31;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid - 1;
        end
        r = lo;
        return r;
    endfunction

    function automatic sample_t look_up(input logic [95:0] d);
        sample_t s;
        longint x, y, z, au, av, v32, uq, vq, w, h, col, row;
        logic [31:0] u32;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        z = longint'($signed(d[47:32]));
        color_known = 1'b1;
        if (!present_cfg)
        begin
            s.color = MAGENTA;
            s.column = '0;
            s.row = '0;
            return s;
        end
        if (x == 0 && z == 0)
        begin
            uq = 32768;
            vq = (y == 0) ? 32768 : (y > 0 ? 0 : 65536);
        end
        else
        begin
            au = turn_angle(x * 16384, z * 16384);
            u32 = 32'(au + 64'sd2147483648);
            uq = ((longint'(u32) + 32768) >> 16) & 16'hFFFF;
            av = turn_angle(floor_root((x * x + z * z) << 28), y * 16384);
            v32 = 64'sd2147483648 - 2 * av;
            if (v32 < 0)
                v32 = 0;
            if (v32 > 64'sd4294967296)
                v32 = 64'sd4294967296;
            vq = (v32 + 32768) >> 16;
        end
        w = (width_cfg == 0) ? 1 : (width_cfg > MAX_WIDTH ? MAX_WIDTH : width_cfg);
        h = (height_cfg == 0) ? 1 : (height_cfg > MAX_HEIGHT ? MAX_HEIGHT : height_cfg);
        col = ((uq * w) >> 16) % w;
        row = (vq * h) >> 16;
        if (row >= h)
            row = h - 1;
        color_known = written[(row * w + col) % STORE_DEPTH];
        s.color = texels[(row * w + col) % STORE_DEPTH];
        s.column = col[7:0];
        s.row = row[6:0];
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_t want, got;
        bit known;
        if (!rst_n)
        begin
            width_cfg <= 9'd256;
            height_cfg <= 8'd128;
            present_cfg <= 1'b0;
            errors = 0;
            expected_samples.delete();
            known_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_MAP_WIDTH:   width_cfg <= cfg_wr_data[8:0];
                    REG_MAP_HEIGHT:  height_cfg <= cfg_wr_data[7:0];
                    REG_MAP_PRESENT: present_cfg <= cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0])
                begin
                    expected_samples.push_back(look_up(s_tdata));
                    known_q.push_back(color_known);
                end
                else
                begin
                    texels[s_tdata[62:48]] = s_tdata[94:63];
                    written[s_tdata[62:48]] = 1'b1;
                end
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[46:0];
                if (expected_samples.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat %h", m_tdata);
                end
                else
                begin
                    want = expected_samples.pop_front();
                    known = known_q.pop_front();
                    if ((known && got.color !== want.color) || got.column !== want.column
                        || got.row !== want.row)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: color %h col %0d row %0d, want %h %0d %0d",
                                     got.color, got.column, got.row,
                                     want.color, want.column, want.row);
                    end
                end
            end
        end
    end

endmodule

### sim/tb_equirect_env_map_sampler_core.sv
// Stimulus and verdict for the equirectangular environment map sampler.
`timescale 1ns / 1ps

module tb_equirect_env_map_sampler_core import esmp_pkg::*;
();

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [1:0]       cfg_index = REG_MAP_WIDTH;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [95:0]      s_tdata = '0;
    logic [0:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [47:0]      m_tdata;
    int               pending;
    int               errors;
    int               cycles = 0;
    bit               tx_idle = 0;
    bit               rx_stall = 0;
    int               idle_pct = 45;
    int               hold_left = 0;

    equirect_env_map_sampler_core u_top (.*);

    esmp_checker u_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= !(rx_stall && $urandom_range(99) < idle_pct);
    end

    task automatic send(input bit cmd, input logic [15:0] x, input logic [15:0] y,
                        input logic [15:0] z, input logic [14:0] addr,
                        input logic [31:0] value);
        while (tx_idle && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {1'b0, value, addr, z, y, x};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
    endtask

    task automatic set_map(input int w, input int h, input bit present);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_MAP_WIDTH;
        cfg_wr_data <= CFG_W'(w);
        @(posedge clk);
        cfg_index <= REG_MAP_HEIGHT;
        cfg_wr_data <= CFG_W'(h);
        @(posedge clk);
        cfg_index <= REG_MAP_PRESENT;
        cfg_wr_data <= CFG_W'(present);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [15:0] pick_dir();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'($signed($urandom_range(16)) - 8);
            2: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        send(1'b1, x, y, z, 15'($urandom), $urandom);
    endtask

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 80)
                sample(pick_dir(), pick_dir(), pick_dir());
            else
                send(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                     15'($urandom), $urandom);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int a = 0; a < 32; a++)
            send(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'(a), $urandom);

        sample(16'h0001, 16'h0002, 16'h0003);
        sample(16'h0000, 16'h0000, 16'h0000);
        set_map(256, 128, 1'b1);
        sample(16'h0000, 16'h0000, 16'h0000);
        sample(16'h0000, 16'h7FFF, 16'h0000);
        sample(16'h0000, 16'h8000, 16'h0000);
        sample(16'h7FFF, 16'h0000, 16'h0000);
        sample(16'h8000, 16'h0000, 16'h0000);
        sample(16'h0000, 16'h0000, 16'h7FFF);
        sample(16'h0000, 16'h0000, 16'h8000);
        sample(16'h8000, 16'h0000, 16'hFFFF);
        sample(16'h8000, 16'h0000, 16'h0001);
        sample(16'h8000, 16'h8000, 16'h8000);
        sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send(1'b0, 16'h0, 16'h0, 16'h0, 15'h7FFF, 32'hFFFF_FFFF);
        send(1'b0, 16'h0, 16'h0, 16'h0, 15'h0000, 32'h0000_0000);
        sample(16'hFFFF, 16'h0001, 16'h0000);

        set_map(511, 255, 1'b1);
        random_run(60);
        set_map(0, 0, 1'b1);
        random_run(30);
        set_map(1, 1, 1'b1);
        random_run(30);

        set_map(37, 19, 1'b1);
        tx_idle = 1;
        random_run(90);
        set_map(200, 100, 1'b1);
        tx_idle = 0;
        rx_stall = 1;
        random_run(90);
        set_map(256, 128, 1'b1);
        tx_idle = 1;
        idle_pct = 8;
        random_run(90);
        set_map(13, 128, 1'b1);
        tx_idle = 0;
        rx_stall = 0;
        idle_pct = 45;
        hold_left <= 300;
        random_run(120);
        set_map(256, 1, 1'b0);
        random_run(40);
        set_map(256, 128, 1'b1);
        random_run(60);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/esmp_pkg.sv
hw/rtl/esmp_cordic.sv
hw/rtl/esmp_isqrt.sv
hw/rtl/esmp_texel_store.sv
hw/rtl/equirect_env_map_sampler_core.sv
sim/esmp_checker.sv
sim/tb_equirect_env_map_sampler_core.sv
